[hw/rtl/irpd_pkg.sv]
// Package of the pulse-distance infrared frame transmitter.
// Holds the item, command and timing types shared by all modules; no dependencies.
package irpd_pkg;

    localparam int DUR_W     = 20;
    localparam int CFG_IDX_W = 3;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MARK        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_MARK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_SPACE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PRE_GAP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_GAP   = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_in_block;
        logic       last_in_block;
        logic       first_in_message;
        logic       last_in_message;
    } in_item_t;

    typedef struct packed {
        logic             carrier_on;
        logic [DUR_W-1:0] duration_us;
        logic             last_segment;
    } out_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] checksum;
        logic       first_in_block;
        logic       last_in_block;
        logic       first_in_message;
        logic       last_in_message;
    } cmd_t;

    typedef struct packed {
        logic [DUR_W-1:0] mark_time;
        logic [DUR_W-1:0] zero_space_time;
        logic [DUR_W-1:0] one_space_time;
        logic [DUR_W-1:0] start_mark_time;
        logic [DUR_W-1:0] start_space_time;
        logic [DUR_W-1:0] preamble_gap_time;
        logic [DUR_W-1:0] block_gap_time;
    } timing_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_PRE_BITS,
        PH_PRE_MARK,
        PH_PRE_GAP,
        PH_START_MARK,
        PH_START_SPACE,
        PH_DATA,
        PH_SUM,
        PH_TRAIL,
        PH_GAP
    } phase_t;

endpackage

[hw/rtl/ir_pulse_distance_frame_tx_core.sv]
// Pulse-distance infrared frame transmitter: timing registers, front end, queue, sequencer.
// Depends on irpd_pkg, irpd_front, irpd_queue and irpd_back.
//
// Each accepted item (one payload byte with its block and message flags) is turned
// into a list of carrier mark and space segments, one segment leaving per clock cycle
// while the output is not stalled. A plain data byte gives 16 segments; block start
// adds 2, block end adds 17 (checksum byte and trailer) plus 1 for the gap between
// blocks, and message start adds 2 * PREAMBLE_ZEROS + 2. An item therefore gives 16
// to 48 segments with the default preamble; the segment sequencer sets throughput.
// A four-entry command queue lets new items be taken while earlier ones are still
// being sent, and the next command starts in the cycle after the last segment of the
// previous one. The user must write the timing registers through the write port only
// while idle, which the block does not enforce; writes to unused indices are ignored.
module ir_pulse_distance_frame_tx_core
    import irpd_pkg::*;
#(
    parameter int PREAMBLE_ZEROS = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data
);

    timing_t timing_reg;
    logic    q_full;
    logic    q_not_empty;
    logic    push;
    logic    pop;
    cmd_t    push_cmd;
    cmd_t    q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.mark_time         <= DUR_W'(430);
            timing_reg.zero_space_time   <= DUR_W'(420);
            timing_reg.one_space_time    <= DUR_W'(1320);
            timing_reg.start_mark_time   <= DUR_W'(3440);
            timing_reg.start_space_time  <= DUR_W'(1720);
            timing_reg.preamble_gap_time <= DUR_W'(26000);
            timing_reg.block_gap_time    <= DUR_W'(35000);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MARK:        timing_reg.mark_time         <= cfg_data;
                REG_ZERO_SPACE:  timing_reg.zero_space_time   <= cfg_data;
                REG_ONE_SPACE:   timing_reg.one_space_time    <= cfg_data;
                REG_START_MARK:  timing_reg.start_mark_time   <= cfg_data;
                REG_START_SPACE: timing_reg.start_space_time  <= cfg_data;
                REG_PRE_GAP:     timing_reg.preamble_gap_time <= cfg_data;
                REG_BLOCK_GAP:   timing_reg.block_gap_time    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    irpd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    irpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    irpd_back #(
        .PREAMBLE_ZEROS (PREAMBLE_ZEROS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .timing      (timing_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

[hw/rtl/irpd_front.sv]
// Front end: accepts input items, keeps the running block sum and builds commands.
// Depends on irpd_pkg.
module irpd_front
    import irpd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    input  logic     q_full,
    output logic     push,
    output cmd_t     push_cmd
);

    logic [7:0] sum_reg;
    logic [7:0] sum_next;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;
    assign sum_next = (in_data.first_in_block ? 8'd0 : sum_reg) + in_data.data_byte;

    always_comb
    begin
        push_cmd.data_byte        = in_data.data_byte;
        push_cmd.checksum         = sum_next;
        push_cmd.first_in_block   = in_data.first_in_block;
        push_cmd.last_in_block    = in_data.last_in_block;
        push_cmd.first_in_message = in_data.first_in_message;
        push_cmd.last_in_message  = in_data.last_in_message;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= 8'd0;
        end
        else if (push)
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

[hw/rtl/irpd_queue.sv]
// Short command queue between the front end and the segment sequencer.
// Depends on irpd_pkg.
module irpd_queue
    import irpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output cmd_t head
);

    cmd_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/irpd_back.sv]
// Segment sequencer: walks the sections of each command and emits one segment a cycle while the output is not stalled.
// Depends on irpd_pkg; takes commands from irpd_queue.
module irpd_back
    import irpd_pkg::*;
#(
    parameter int PREAMBLE_ZEROS = 5
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  timing_t   timing,
    input  logic      q_not_empty,
    input  cmd_t      q_head,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int PRE_SEGS = 2 * PREAMBLE_ZEROS;
    localparam int CNT_W    = (PRE_SEGS > 16) ? $clog2(PRE_SEGS) : 4;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    cmd_t             cmd_reg;
    cmd_t             cmd_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_item_t        out_data_reg;
    out_item_t        out_data_next;

    logic             advance;
    logic             emit;
    logic             seg_on;
    logic [DUR_W-1:0] seg_dur;
    logic             section_end;
    phase_t           successor;
    logic             data_bit;
    logic             cmd_done;

    function automatic phase_t entry_phase(input cmd_t c);
        phase_t p;
        if (c.first_in_message)
        begin
            p = (PRE_SEGS > 0) ? PH_PRE_BITS : PH_PRE_MARK;
        end
        else if (c.first_in_block)
        begin
            p = PH_START_MARK;
        end
        else
        begin
            p = PH_DATA;
        end
        return p;
    endfunction

    assign advance   = !out_valid_reg || !out_stall;
    assign emit      = advance && (phase_reg != PH_IDLE);
    assign cmd_done  = emit && section_end && (successor == PH_IDLE);
    assign pop       = q_not_empty && ((phase_reg == PH_IDLE) || cmd_done);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        seg_on      = 1'b0;
        seg_dur     = '0;
        section_end = 1'b1;
        successor   = PH_IDLE;
        data_bit    = (phase_reg == PH_SUM) ? cmd_reg.checksum[cnt_reg[3:1]]
                                            : cmd_reg.data_byte[cnt_reg[3:1]];
        case (phase_reg)
            PH_PRE_BITS:
            begin
                seg_on      = !cnt_reg[0];
                seg_dur     = cnt_reg[0] ? timing.zero_space_time : timing.mark_time;
                section_end = (cnt_reg == CNT_W'(PRE_SEGS - 1));
                successor   = PH_PRE_MARK;
            end
            PH_PRE_MARK:
            begin
                seg_on    = 1'b1;
                seg_dur   = timing.mark_time;
                successor = PH_PRE_GAP;
            end
            PH_PRE_GAP:
            begin
                seg_dur   = timing.preamble_gap_time;
                successor = cmd_reg.first_in_block ? PH_START_MARK : PH_DATA;
            end
            PH_START_MARK:
            begin
                seg_on    = 1'b1;
                seg_dur   = timing.start_mark_time;
                successor = PH_START_SPACE;
            end
            PH_START_SPACE:
            begin
                seg_dur   = timing.start_space_time;
                successor = PH_DATA;
            end
            PH_DATA, PH_SUM:
            begin
                seg_on      = !cnt_reg[0];
                seg_dur     = !cnt_reg[0] ? timing.mark_time :
                              data_bit    ? timing.one_space_time : timing.zero_space_time;
                section_end = (cnt_reg == CNT_W'(15));
                if (phase_reg == PH_SUM)
                begin
                    successor = PH_TRAIL;
                end
                else
                begin
                    successor = cmd_reg.last_in_block ? PH_SUM : PH_IDLE;
                end
            end
            PH_TRAIL:
            begin
                seg_on    = 1'b1;
                seg_dur   = timing.mark_time;
                successor = cmd_reg.last_in_message ? PH_IDLE : PH_GAP;
            end
            PH_GAP:
            begin
                seg_dur   = timing.block_gap_time;
                successor = PH_IDLE;
            end
            default:
            begin
                section_end = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance)
        begin
            out_valid_next = emit;
            out_data_next.carrier_on   = seg_on;
            out_data_next.duration_us  = seg_dur;
            out_data_next.last_segment = cmd_done;
        end
        if (emit)
        begin
            if (section_end)
            begin
                phase_next = successor;
                cnt_next   = '0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        if (pop)
        begin
            phase_next = entry_phase(q_head);
            cnt_next   = '0;
            cmd_next   = q_head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_data_reg <= out_data_next;
    end

endmodule

[tb/irpd_segment_checker.sv]
`timescale 1ns / 1ps
// Segment checker for the pulse-distance infrared frame transmitter: watches both channels
// and the timing write port, works out the expected segments of every item and compares.
// Depends on irpd_pkg.
module irpd_segment_checker
    import irpd_pkg::*;
#(
    parameter int PREAMBLE_ZEROS = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  in_item_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  out_item_t            out_data,
    output int                   error_count,
    output int                   segments_pending,
    output int                   segments_seen
);

    timing_t    timing;
    logic [7:0] running_sum;
    out_item_t  expected_segments[$];
    int         mismatches;
    int         checked;

    task automatic push_segment(input logic on, input logic [DUR_W-1:0] dur);
        out_item_t seg;
        seg.carrier_on   = on;
        seg.duration_us  = dur;
        seg.last_segment = 1'b0;
        expected_segments.push_back(seg);
    endtask

    task automatic push_byte_bits(input logic [7:0] value);
        int i;
        for (i = 0; i < 8; i++)
        begin
            push_segment(1'b1, timing.mark_time);
            push_segment(1'b0, value[i] ? timing.one_space_time : timing.zero_space_time);
        end
    endtask

    task automatic expand_item_to_segments(input in_item_t item);
        int        i;
        out_item_t tail;
        if (item.first_in_message)
        begin
            for (i = 0; i < PREAMBLE_ZEROS; i++)
            begin
                push_segment(1'b1, timing.mark_time);
                push_segment(1'b0, timing.zero_space_time);
            end
            push_segment(1'b1, timing.mark_time);
            push_segment(1'b0, timing.preamble_gap_time);
        end
        if (item.first_in_block)
        begin
            push_segment(1'b1, timing.start_mark_time);
            push_segment(1'b0, timing.start_space_time);
            running_sum = 8'd0;
        end
        push_byte_bits(item.data_byte);
        running_sum = running_sum + item.data_byte;
        if (item.last_in_block)
        begin
            push_byte_bits(running_sum);
            push_segment(1'b1, timing.mark_time);
            if (!item.last_in_message)
            begin
                push_segment(1'b0, timing.block_gap_time);
            end
        end
        tail = expected_segments.pop_back();
        tail.last_segment = 1'b1;
        expected_segments.push_back(tail);
    endtask

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t wanted;
        if (!rst_n)
        begin
            timing.mark_time         = 20'd430;
            timing.zero_space_time   = 20'd420;
            timing.one_space_time    = 20'd1320;
            timing.start_mark_time   = 20'd3440;
            timing.start_space_time  = 20'd1720;
            timing.preamble_gap_time = 20'd26000;
            timing.block_gap_time    = 20'd35000;
            running_sum = 8'd0;
            expected_segments.delete();
            mismatches = 0;
            checked    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MARK:        timing.mark_time         = cfg_data;
                    REG_ZERO_SPACE:  timing.zero_space_time   = cfg_data;
                    REG_ONE_SPACE:   timing.one_space_time    = cfg_data;
                    REG_START_MARK:  timing.start_mark_time   = cfg_data;
                    REG_START_SPACE: timing.start_space_time  = cfg_data;
                    REG_PRE_GAP:     timing.preamble_gap_time = cfg_data;
                    REG_BLOCK_GAP:   timing.block_gap_time    = cfg_data;
                    default:         ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                expand_item_to_segments(in_data);
            end
            if (out_valid && !out_stall)
            begin
                checked++;
                if (expected_segments.size() == 0)
                begin
                    note_failure($sformatf("segment %0d arrived with none expected: on=%0b dur=%0d last=%0b",
                                           checked, out_data.carrier_on, out_data.duration_us,
                                           out_data.last_segment));
                end
                else
                begin
                    wanted = expected_segments.pop_front();
                    if (out_data.carrier_on !== wanted.carrier_on
                        || out_data.duration_us !== wanted.duration_us
                        || out_data.last_segment !== wanted.last_segment)
                    begin
                        note_failure($sformatf({"segment %0d: expected on=%0b dur=%0d last=%0b,",
                                                " got on=%0b dur=%0d last=%0b"},
                                               checked, wanted.carrier_on, wanted.duration_us,
                                               wanted.last_segment, out_data.carrier_on,
                                               out_data.duration_us, out_data.last_segment));
                    end
                end
            end
        end
        error_count      <= mismatches;
        segments_pending <= expected_segments.size();
        segments_seen    <= checked;
    end

endmodule

[tb/ir_pulse_distance_frame_tx_core_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the pulse-distance infrared frame transmitter: clock, reset, timing
// programming, directed and random items, receiver stalls and the verdict.
// Depends on irpd_pkg, ir_pulse_distance_frame_tx_core and irpd_segment_checker.
module ir_pulse_distance_frame_tx_core_tb;
    import irpd_pkg::*;

    localparam int PREAMBLE_ZEROS = 5;
    localparam int RANDOM_ITEMS   = 430;
    localparam int NUM_SETTINGS   = 5;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IN_ITEM_W      = $bits(in_item_t);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_RUNS
    } stall_mode_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DUR_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;

    int error_count;
    int segments_pending;
    int segments_seen;
    int items_sent  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          run_left   = 0;

    ir_pulse_distance_frame_tx_core #(
        .PREAMBLE_ZEROS(PREAMBLE_ZEROS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    irpd_segment_checker #(
        .PREAMBLE_ZEROS(PREAMBLE_ZEROS)
    ) u_segment_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_data          (in_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_data         (out_data),
        .error_count      (error_count),
        .segments_pending (segments_pending),
        .segments_seen    (segments_seen)
    );

    always #2 clk = ~clk;

    // The receiver switches between stall patterns of its own, independent of the sender.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode <= STALL_NONE;
            mode_left  <= 50;
            run_left   <= 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= stall_mode_t'($urandom_range(0, 3));
                mode_left  <= $urandom_range(40, 300);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    if (run_left == 0)
                    begin
                        out_stall <= ~out_stall;
                        run_left  <= $urandom_range(1, 30);
                    end
                    else
                    begin
                        run_left <= run_left - 1;
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired with %0d segments still expected", segments_pending);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic in_item_t make_item(input logic [7:0] data, input logic fb,
                                           input logic lb, input logic fm, input logic lm);
        in_item_t item;
        item.data_byte        = data;
        item.first_in_block   = fb;
        item.last_in_block    = lb;
        item.first_in_message = fm;
        item.last_in_message  = lm;
        return item;
    endfunction

    function automatic timing_t random_timing(input int unsigned max_value);
        timing_t t;
        t.mark_time         = DUR_W'($urandom_range(0, max_value));
        t.zero_space_time   = DUR_W'($urandom_range(0, max_value));
        t.one_space_time    = DUR_W'($urandom_range(0, max_value));
        t.start_mark_time   = DUR_W'($urandom_range(0, max_value));
        t.start_space_time  = DUR_W'($urandom_range(0, max_value));
        t.preamble_gap_time = DUR_W'($urandom_range(0, max_value));
        t.block_gap_time    = DUR_W'($urandom_range(0, max_value));
        return t;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DUR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic program_timing(input timing_t t);
        write_reg(REG_MARK, t.mark_time);
        write_reg(REG_ZERO_SPACE, t.zero_space_time);
        write_reg(REG_ONE_SPACE, t.one_space_time);
        write_reg(REG_START_MARK, t.start_mark_time);
        write_reg(REG_START_SPACE, t.start_space_time);
        write_reg(REG_PRE_GAP, t.preamble_gap_time);
        write_reg(REG_BLOCK_GAP, t.block_gap_time);
        write_reg(REG_UNUSED, DUR_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Items go out in bursts; a new burst may start after a gap with valid low.
    task automatic send_item(input in_item_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 10);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic send_random_frame();
        int nblocks;
        int nbytes;
        int b;
        int i;
        nblocks = $urandom_range(1, 3);
        for (b = 0; b < nblocks; b++)
        begin
            nbytes = $urandom_range(1, 5);
            for (i = 0; i < nbytes; i++)
            begin
                send_item(make_item(8'($urandom), i == 0, i == nbytes - 1,
                                    b == 0 && i == 0, b == nblocks - 1 && i == nbytes - 1));
            end
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (segments_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        in_item_t directed_items[$];
        timing_t  settings[NUM_SETTINGS];
        int       phase;
        int       phase_target;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset timing: extremes of the byte, every section alone and combined, a message
        // end without a block end, and the sum running on across a block end.
        directed_items.push_back(make_item(8'h00, 1'b1, 1'b0, 1'b1, 1'b0));
        directed_items.push_back(make_item(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0));
        directed_items.push_back(make_item(8'h01, 1'b0, 1'b0, 1'b0, 1'b0));
        directed_items.push_back(make_item(8'h80, 1'b0, 1'b1, 1'b0, 1'b0));
        directed_items.push_back(make_item(8'h5A, 1'b1, 1'b0, 1'b0, 1'b0));
        directed_items.push_back(make_item(8'hA5, 1'b0, 1'b1, 1'b0, 1'b1));
        directed_items.push_back(make_item(8'h3C, 1'b0, 1'b0, 1'b0, 1'b1));
        directed_items.push_back(make_item(8'hC3, 1'b0, 1'b1, 1'b0, 1'b0));
        directed_items.push_back(make_item(8'hFF, 1'b1, 1'b1, 1'b1, 1'b0));
        directed_items.push_back(make_item(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1));
        directed_items.push_back(make_item(8'h00, 1'b0, 1'b0, 1'b1, 1'b0));
        directed_items.push_back(make_item(8'h00, 1'b1, 1'b1, 1'b0, 1'b1));
        directed_items.push_back(make_item(8'h7F, 1'b0, 1'b0, 1'b0, 1'b0));
        directed_items.push_back(make_item(8'hFE, 1'b1, 1'b1, 1'b0, 1'b0));
        directed_items.push_back(make_item(8'h81, 1'b0, 1'b1, 1'b1, 1'b1));
        foreach (directed_items[k])
        begin
            send_item(directed_items[k]);
        end
        wait_idle();

        settings[0] = '0;
        settings[1] = '1;
        settings[2] = random_timing(20'hFFFFF);
        settings[3] = random_timing(3000);
        settings[4] = random_timing(100);
        for (phase = 0; phase < NUM_SETTINGS; phase++)
        begin
            program_timing(settings[phase]);
            phase_target = items_sent + RANDOM_ITEMS / NUM_SETTINGS;
            while (items_sent < phase_target)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    send_random_frame();
                end
                else
                begin
                    send_item(in_item_t'(IN_ITEM_W'($urandom)));
                end
            end
            wait_idle();
        end

        $display("Sent %0d items under the reset timing and %0d programmed timing sets.",
                 items_sent, NUM_SETTINGS);
        $display("Checked %0d segments, %0d mismatches.", segments_seen, error_count);
        if (error_count == 0 && segments_pending == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/irpd_pkg.sv
hw/rtl/irpd_front.sv
hw/rtl/irpd_queue.sv
hw/rtl/irpd_back.sv
hw/rtl/ir_pulse_distance_frame_tx_core.sv
tb/irpd_segment_checker.sv
tb/ir_pulse_distance_frame_tx_core_tb.sv
